// ----- sv/lmsd_pkg.sv -----
`timescale 1ns / 1ps
// Package for the loop mass storage drive: transaction types, command codes,
// status constants and the geometry table. No dependencies.
package lmsd_pkg;

    localparam int SECTOR_COUNT_DEF = 2560;
    localparam int SECTOR_BYTES     = 256;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] frame_byte;
        logic       end_mark;
        logic       listen_addressed;
        logic       talk_addressed;
    } t_in;

    typedef struct packed {
        logic [7:0] out_value;
        logic       no_data;
    } t_out;

    // Actions of an input transaction.
    localparam logic [2:0] ACT_DATA_IN  = 3'd0;
    localparam logic [2:0] ACT_REQ_OUT  = 3'd1;
    localparam logic [2:0] ACT_STATUS   = 3'd2;
    localparam logic [2:0] ACT_CLEAR    = 3'd3;
    localparam logic [2:0] ACT_COMMAND  = 3'd4;

    // Command groups in the upper three frame bits.
    localparam logic [2:0] GRP_LISTEN = 3'd5;
    localparam logic [2:0] GRP_TALK   = 3'd6;

    // Listen modes.
    localparam logic [4:0] L_DATA      = 5'd0;
    localparam logic [4:0] L_AUX       = 5'd1;
    localparam logic [4:0] L_DATA_BP0  = 5'd2;
    localparam logic [4:0] L_SET_BP    = 5'd3;
    localparam logic [4:0] L_SEEK      = 5'd4;
    localparam logic [4:0] L_FORMAT    = 5'd5;
    localparam logic [4:0] L_PARTIAL   = 5'd6;
    localparam logic [4:0] L_RESET_PTR = 5'd7;
    localparam logic [4:0] L_FLUSH     = 5'd8;
    localparam logic [4:0] L_COPY      = 5'd9;
    localparam logic [4:0] L_SWAP      = 5'd10;

    // Talk modes.
    localparam logic [4:0] T_DATA = 5'd0;
    localparam logic [4:0] T_AUX  = 5'd1;
    localparam logic [4:0] T_READ = 5'd2;
    localparam logic [4:0] T_POS  = 5'd3;
    localparam logic [4:0] T_SWAP = 5'd4;
    localparam logic [4:0] T_GEOM = 5'd6;
    localparam logic [4:0] T_SIZE = 5'd7;
    localparam logic [4:0] T_DONE = 5'd15;

    localparam logic [7:0] STATUS_SEEK_ERR = 8'd28;
    localparam logic [7:0] STATUS_KEEP     = 8'hE0;
    localparam logic [7:0] BLANK_BYTE      = 8'hFF;
    localparam logic [3:0] GEOM_LEN        = 4'd12;

    function automatic logic [7:0] geometry(input logic [3:0] idx);
        logic [7:0] v;
        case (idx)
            4'd3:    v = 8'd80;
            4'd7:    v = 8'd2;
            4'd11:   v = 8'd16;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

endpackage

// ----- sv/loop_mass_storage_drive.sv -----
`timescale 1ns / 1ps
// Top level of the loop mass storage drive: command decode, sequencer and
// memories. Depends on lmsd_pkg and lmsd_ram.
//
//  channel  direction  handshake                    payload
//  in       input      i_in_valid / o_in_stall      i_in  (t_in)
//  out      output     o_out_valid / i_out_stall    o_out (t_out)
//  config   input      i_cfg_we (no wait)           i_cfg_idx, i_cfg_data
//
// A byte transaction is accepted in S_IDLE and passes S_NEXT and S_DONE; S_DONE
// loads the result into the output register and returns to S_IDLE for the next
// one. A buffered byte request adds the S_OUTRD state for the buffer read.
// Transactions that move a sector, copy a buffer or fill a buffer add an S_SWEEP
// pass per move, one byte per cycle through the single buffer and store ports.
// Format clears one sector tag per cycle, over all SECTOR_COUNT tags.
// After reset a clearing pass over max(SECTOR_COUNT, 256) addresses blanks the
// sector tags and zeroes both buffers; o_in_stall is high during it.
// A finished result sits in the output register; the next transaction is taken
// while it waits, and only its own completion waits on i_out_stall.
module loop_mass_storage_drive #(
    parameter int SECTOR_COUNT = lmsd_pkg::SECTOR_COUNT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  lmsd_pkg::t_in i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output lmsd_pkg::t_out o_out,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic          i_cfg_data
);
    import lmsd_pkg::*;

    // The store holds the sector bytes; a one-bit tag per sector tells whether
    // the sector was written since the last format. An untagged sector reads
    // as blank, so format only has to sweep the tags.
    localparam int STORE_DEPTH = SECTOR_COUNT * SECTOR_BYTES;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int TAG_AW      = (SECTOR_COUNT > 1) ? $clog2(SECTOR_COUNT) : 1;
    localparam int CLR_N       = (SECTOR_COUNT > SECTOR_BYTES) ? SECTOR_COUNT : SECTOR_BYTES;
    localparam int CW          = $clog2(CLR_N + 1);
    localparam logic [16:0] SC_W     = 17'(SECTOR_COUNT);
    localparam logic [15:0] SC_16    = 16'(SECTOR_COUNT);
    localparam logic [CW-1:0] CNT_SEC = CW'(SECTOR_BYTES);
    localparam logic [CW-1:0] CNT_FMT = CW'(SECTOR_COUNT);
    localparam logic [CW-1:0] CNT_CLR = CW'(CLR_N);

    typedef enum logic [2:0] {
        S_IDLE, S_OUTRD, S_NEXT, S_TAGRD, S_SWEEP, S_DONE
    } t_state;

    typedef enum logic [2:0] {
        SW_WRITE, SW_READ, SW_FILL, SW_COPY, SW_FMT, SW_INIT
    } t_sweep;

    t_state       r_state;
    t_sweep       r_kind;
    logic [CW-1:0] r_cnt;
    logic         r_tag;

    logic         r_dp, r_wp;
    logic [7:0]   r_status;
    logic [4:0]   r_lm, r_tm;
    logic [7:0]   r_bp;
    logic [15:0]  r_sp;
    logic [15:0]  r_acc;
    logic         r_seek2;
    logic         r_pw;
    logic [3:0]   r_tc;
    logic         r_bsel;

    // Work still owed by the current transaction, taken in this order.
    logic         r_do_wr, r_inc_mid, r_do_rd, r_inc_end, r_do_copy, r_do_fmt;

    logic [7:0]   r_pv;
    logic         r_pnd;
    logic         r_ovalid;
    t_out         r_out;

    logic         accept;
    logic [CW-1:0] wi;
    logic         sweep_wr;
    logic [CW-1:0] cnt_last;

    logic [7:0]   main_raddr, main_waddr, main_wdata, main_rdata;
    logic         main_we;
    logic [7:0]   aux_raddr, aux_waddr, aux_wdata, aux_rdata;
    logic         aux_we;
    logic [7:0]   a_raddr, a_waddr, a_wdata, a_rdata;
    logic         a_we;
    logic [7:0]   b_raddr, b_waddr, b_wdata, b_rdata;
    logic         b_we;

    logic         store_we;
    logic [STORE_AW-1:0] store_waddr, store_raddr;
    logic [7:0]   store_rdata;
    logic         tag_we, tag_wdata, tag_rdata;
    logic [TAG_AW-1:0] tag_waddr, tag_raddr;

    logic [23:0]  store_wfull, store_rfull;
    logic         sp_in_range;
    logic         in_main_mode;
    logic [7:0]   bp_inc;
    logic [15:0]  seek_full;

    assign accept       = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_ovalid;
    assign o_out        = r_out;

    assign wi          = r_cnt - CW'(1);
    assign sweep_wr    = (r_state == S_SWEEP) && (r_cnt != '0);
    assign sp_in_range = ({1'b0, r_sp} < SC_W);
    assign bp_inc      = r_bp + 8'd1;
    assign seek_full   = {r_acc[15:8], i_in.frame_byte};
    assign in_main_mode = (r_lm == L_DATA) || (r_lm == L_DATA_BP0) || (r_lm == L_PARTIAL);

    always_comb begin
        case (r_kind)
            SW_FMT:  cnt_last = CNT_FMT;
            SW_INIT: cnt_last = CNT_CLR;
            default: cnt_last = CNT_SEC;
        endcase
    end

    // Main and aux buffer ports; the swap flag maps them onto the two RAMs.
    always_comb begin
        main_raddr = (r_state == S_SWEEP) ? r_cnt[7:0] : r_bp;
        main_we    = 1'b0;
        main_waddr = wi[7:0];
        main_wdata = BLANK_BYTE;
        aux_raddr  = r_bp;
        aux_we     = 1'b0;
        aux_waddr  = wi[7:0];
        aux_wdata  = main_rdata;
        if (accept && (i_in.action == ACT_DATA_IN) && in_main_mode) begin
            main_we    = 1'b1;
            main_waddr = r_bp;
            main_wdata = i_in.frame_byte;
        end else if (sweep_wr && (r_kind == SW_READ)) begin
            main_we    = 1'b1;
            main_wdata = r_tag ? store_rdata : BLANK_BYTE;
        end else if (sweep_wr && (r_kind == SW_FILL)) begin
            main_we    = 1'b1;
        end else if (sweep_wr && (r_kind == SW_INIT) && (wi < CNT_SEC)) begin
            main_we    = 1'b1;
            main_wdata = 8'd0;
        end
        if (accept && (i_in.action == ACT_DATA_IN) && (r_lm == L_AUX)) begin
            aux_we    = 1'b1;
            aux_waddr = r_bp;
            aux_wdata = i_in.frame_byte;
        end else if (sweep_wr && (r_kind == SW_COPY)) begin
            aux_we    = 1'b1;
        end else if (sweep_wr && (r_kind == SW_INIT) && (wi < CNT_SEC)) begin
            aux_we    = 1'b1;
            aux_wdata = 8'd0;
        end
    end

    always_comb begin
        if (r_bsel) begin
            b_we = main_we; b_waddr = main_waddr; b_wdata = main_wdata; b_raddr = main_raddr;
            a_we = aux_we;  a_waddr = aux_waddr;  a_wdata = aux_wdata;  a_raddr = aux_raddr;
            main_rdata = b_rdata;
            aux_rdata  = a_rdata;
        end else begin
            a_we = main_we; a_waddr = main_waddr; a_wdata = main_wdata; a_raddr = main_raddr;
            b_we = aux_we;  b_waddr = aux_waddr;  b_wdata = aux_wdata;  b_raddr = aux_raddr;
            main_rdata = a_rdata;
            aux_rdata  = b_rdata;
        end
    end

    // Store and tag ports. A sector write tags its sector on the last cycle.
    assign store_wfull = {r_sp, wi[7:0]};
    assign store_rfull = {r_sp, r_cnt[7:0]};
    assign store_we    = sweep_wr && (r_kind == SW_WRITE);
    assign store_waddr = store_wfull[STORE_AW-1:0];
    assign store_raddr = store_rfull[STORE_AW-1:0];
    assign tag_raddr   = r_sp[TAG_AW-1:0];

    always_comb begin
        tag_we    = 1'b0;
        tag_waddr = r_sp[TAG_AW-1:0];
        tag_wdata = 1'b1;
        if ((r_state == S_SWEEP) && (r_kind == SW_WRITE) && (r_cnt == CNT_SEC)) begin
            tag_we = 1'b1;
        end else if (sweep_wr && ((r_kind == SW_FMT) || (r_kind == SW_INIT))
                     && (wi < CNT_FMT)) begin
            tag_we    = 1'b1;
            tag_waddr = wi[TAG_AW-1:0];
            tag_wdata = 1'b0;
        end
    end

    lmsd_ram #(.WIDTH(8), .DEPTH(SECTOR_BYTES)) u_buf_a (
        .i_clk(i_clk), .i_we(a_we), .i_waddr(a_waddr), .i_wdata(a_wdata),
        .i_raddr(a_raddr), .o_rdata(a_rdata)
    );

    lmsd_ram #(.WIDTH(8), .DEPTH(SECTOR_BYTES)) u_buf_b (
        .i_clk(i_clk), .i_we(b_we), .i_waddr(b_waddr), .i_wdata(b_wdata),
        .i_raddr(b_raddr), .o_rdata(b_rdata)
    );

    lmsd_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
        .i_clk(i_clk), .i_we(store_we), .i_waddr(store_waddr), .i_wdata(main_rdata),
        .i_raddr(store_raddr), .o_rdata(store_rdata)
    );

    lmsd_ram #(.WIDTH(1), .DEPTH(SECTOR_COUNT)) u_tag (
        .i_clk(i_clk), .i_we(tag_we), .i_waddr(tag_waddr), .i_wdata(tag_wdata),
        .i_raddr(tag_raddr), .o_rdata(tag_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_SWEEP;
            r_kind    <= SW_INIT;
            r_cnt     <= '0;
            r_dp      <= 1'b1;
            r_wp      <= 1'b0;
            r_status  <= '0;
            r_lm      <= '0;
            r_tm      <= '0;
            r_bp      <= '0;
            r_sp      <= '0;
            r_acc     <= '0;
            r_seek2   <= 1'b0;
            r_pw      <= 1'b0;
            r_tc      <= '0;
            r_bsel    <= 1'b0;
            r_do_wr   <= 1'b0;
            r_inc_mid <= 1'b0;
            r_do_rd   <= 1'b0;
            r_inc_end <= 1'b0;
            r_do_copy <= 1'b0;
            r_do_fmt  <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx) begin
                    r_wp <= i_cfg_data;
                end else begin
                    r_dp <= i_cfg_data;
                end
            end

            // In S_DONE the output register is reloaded below instead.
            if (r_ovalid && !i_out_stall && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_pv      <= 8'd0;
                        r_pnd     <= 1'b0;
                        r_do_wr   <= 1'b0;
                        r_inc_mid <= 1'b0;
                        r_do_rd   <= 1'b0;
                        r_inc_end <= 1'b0;
                        r_do_copy <= 1'b0;
                        r_do_fmt  <= 1'b0;
                        r_state   <= S_NEXT;
                        unique case (i_in.action)
                            ACT_DATA_IN: begin
                                unique case (r_lm) inside
                                    L_DATA, L_DATA_BP0, L_PARTIAL: begin
                                        r_bp <= bp_inc;
                                        if (bp_inc == 8'd0) begin
                                            r_do_wr   <= 1'b1;
                                            r_inc_mid <= 1'b1;
                                            r_do_rd   <= r_pw;
                                        end else if (i_in.end_mark) begin
                                            r_do_wr   <= 1'b1;
                                            r_inc_mid <= !r_pw;
                                        end
                                    end
                                    L_AUX: r_bp <= bp_inc;
                                    L_SET_BP: r_bp <= i_in.frame_byte;
                                    L_SEEK: begin
                                        if (r_seek2) begin
                                            r_acc <= seek_full;
                                            if (seek_full < SC_16 || SECTOR_COUNT > 65535) begin
                                                r_sp     <= seek_full;
                                                r_status <= 8'd0;
                                            end else begin
                                                r_status <= STATUS_SEEK_ERR;
                                            end
                                            r_seek2 <= 1'b0;
                                        end else begin
                                            r_acc   <= {i_in.frame_byte, r_acc[7:0]};
                                            r_seek2 <= 1'b1;
                                        end
                                    end
                                    default: ;
                                endcase
                            end
                            ACT_REQ_OUT: begin
                                unique case (r_tm) inside
                                    T_DATA, T_READ, T_AUX: r_state <= S_OUTRD;
                                    T_POS: begin
                                        if (r_tc == 4'd0) begin
                                            r_pv <= r_sp[15:8];
                                        end else if (r_tc == 4'd1) begin
                                            r_pv <= r_sp[7:0];
                                        end else if (r_tc == 4'd2) begin
                                            r_pv <= r_bp;
                                        end else begin
                                            r_pnd <= 1'b1;
                                        end
                                        if (r_tc != 4'd15) r_tc <= r_tc + 4'd1;
                                    end
                                    T_GEOM: begin
                                        if (r_tc < GEOM_LEN) begin
                                            r_pv <= geometry(r_tc);
                                            r_tc <= r_tc + 4'd1;
                                        end else begin
                                            r_pnd <= 1'b1;
                                        end
                                    end
                                    T_SIZE: begin
                                        if (r_tc == 4'd0) begin
                                            r_pv <= SC_16[15:8];
                                        end else if (r_tc == 4'd1) begin
                                            r_pv <= SC_16[7:0];
                                        end else begin
                                            r_pnd <= 1'b1;
                                        end
                                        if (r_tc != 4'd15) r_tc <= r_tc + 4'd1;
                                    end
                                    default: r_pnd <= 1'b1;
                                endcase
                            end
                            ACT_STATUS: begin
                                r_pv     <= r_status;
                                r_status <= r_status & STATUS_KEEP;
                            end
                            ACT_CLEAR: begin
                                r_seek2 <= 1'b0;
                                r_sp    <= '0;
                                r_bp    <= '0;
                            end
                            ACT_COMMAND: begin
                                r_pv <= i_in.frame_byte;
                                if ((i_in.frame_byte[7:5] == GRP_LISTEN)
                                    && i_in.listen_addressed && !i_in.talk_addressed) begin
                                    r_lm <= i_in.frame_byte[4:0];
                                    unique case (i_in.frame_byte[4:0])
                                        L_AUX: r_pw <= 1'b0;
                                        L_DATA_BP0: begin
                                            r_bp <= '0;
                                            r_pw <= 1'b0;
                                        end
                                        L_SEEK: begin
                                            r_pw    <= 1'b0;
                                            r_seek2 <= 1'b0;
                                        end
                                        L_FORMAT: begin
                                            r_status <= 8'd0;
                                            r_do_fmt <= r_dp && !r_wp;
                                        end
                                        L_PARTIAL: begin
                                            r_pw    <= 1'b1;
                                            r_do_rd <= 1'b1;
                                        end
                                        L_RESET_PTR: begin
                                            r_seek2 <= 1'b0;
                                            r_sp    <= '0;
                                            r_bp    <= '0;
                                        end
                                        L_FLUSH: begin
                                            r_do_wr   <= 1'b1;
                                            r_inc_mid <= !r_pw;
                                        end
                                        L_COPY: begin
                                            r_bp      <= '0;
                                            r_do_copy <= 1'b1;
                                        end
                                        L_SWAP: begin
                                            r_bp   <= '0;
                                            r_bsel <= !r_bsel;
                                        end
                                        default: ;
                                    endcase
                                end else if ((i_in.frame_byte[7:5] == GRP_TALK)
                                             && i_in.talk_addressed) begin
                                    r_tm <= i_in.frame_byte[4:0];
                                    r_tc <= '0;
                                    unique case (i_in.frame_byte[4:0])
                                        T_DATA: r_pw <= 1'b0;
                                        T_READ: begin
                                            r_do_rd   <= 1'b1;
                                            r_inc_end <= 1'b1;
                                            r_bp      <= '0;
                                            r_pw      <= 1'b0;
                                        end
                                        T_SWAP: begin
                                            r_bp   <= '0;
                                            r_bsel <= !r_bsel;
                                        end
                                        default: ;
                                    endcase
                                end
                            end
                            default: ;
                        endcase
                    end
                end

                // Buffer byte arrives in the cycle after its address.
                S_OUTRD: begin
                    r_pv <= (r_tm == T_AUX) ? aux_rdata : main_rdata;
                    r_bp <= bp_inc;
                    if (bp_inc == 8'd0) begin
                        if (r_tm == T_AUX) begin
                            r_tm <= T_DONE;
                        end else begin
                            r_do_rd   <= 1'b1;
                            r_inc_end <= 1'b1;
                        end
                    end
                    r_state <= S_NEXT;
                end

                S_NEXT: begin
                    r_cnt <= '0;
                    if (r_do_wr) begin
                        if (r_dp && !r_wp && sp_in_range) begin
                            r_kind  <= SW_WRITE;
                            r_state <= S_SWEEP;
                        end else begin
                            r_do_wr <= 1'b0;
                            if (r_inc_mid) r_sp <= sat_inc16(r_sp);
                        end
                    end else if (r_do_rd) begin
                        if (!r_dp) begin
                            r_do_rd <= 1'b0;
                            if (r_inc_end) r_sp <= sat_inc16(r_sp);
                        end else if (sp_in_range) begin
                            r_state <= S_TAGRD;
                        end else begin
                            r_kind  <= SW_FILL;
                            r_state <= S_SWEEP;
                        end
                    end else if (r_do_copy) begin
                        r_kind  <= SW_COPY;
                        r_state <= S_SWEEP;
                    end else if (r_do_fmt) begin
                        r_kind  <= SW_FMT;
                        r_state <= S_SWEEP;
                    end else begin
                        r_state <= S_DONE;
                    end
                end

                S_TAGRD: begin
                    r_tag   <= tag_rdata;
                    r_kind  <= SW_READ;
                    r_state <= S_SWEEP;
                end

                S_SWEEP: begin
                    if (r_cnt == cnt_last) begin
                        r_state <= S_NEXT;
                        unique case (r_kind)
                            SW_WRITE: begin
                                r_do_wr <= 1'b0;
                                if (r_inc_mid) r_sp <= sat_inc16(r_sp);
                            end
                            SW_READ, SW_FILL: begin
                                r_do_rd <= 1'b0;
                                if (r_inc_end) r_sp <= sat_inc16(r_sp);
                            end
                            SW_COPY: r_do_copy <= 1'b0;
                            SW_FMT:  r_do_fmt  <= 1'b0;
                            default: r_state   <= S_IDLE;
                        endcase
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end

                S_DONE: begin
                    if (!r_ovalid || !i_out_stall) begin
                        r_out.out_value <= r_pv;
                        r_out.no_data   <= r_pnd;
                        r_ovalid        <= 1'b1;
                        r_state         <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- sv/lmsd_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module lmsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for loop_mass_storage_drive: a directed table followed
// by random command/data sequences, checked against an in-bench drive model.
// Depends on lmsd_pkg and the drive RTL.
module testbench;
    import lmsd_pkg::*;

    localparam int NUM_SECTORS = SECTOR_COUNT_DEF;
    localparam int STORE_SIZE  = NUM_SECTORS * SECTOR_BYTES;
    localparam int DRAIN_CYCLES = 3000;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in  i_in;
    logic o_out_valid;
    logic i_out_stall;
    t_out o_out;
    logic i_cfg_we;
    logic i_cfg_idx;
    logic i_cfg_data;

    loop_mass_storage_drive dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Mirror of the drive state, updated once per accepted input transaction.
    bit [7:0]  disk_image [STORE_SIZE];
    bit [7:0]  main_buf [256];
    bit [7:0]  aux_buf [256];
    bit [7:0]  status_byte;
    bit [4:0]  lmode;
    bit [4:0]  tmode;
    bit [7:0]  bptr;
    bit [15:0] sptr;
    bit [15:0] seek_acc;
    bit        seek_hi_done;
    bit        partial_on;
    bit [3:0]  tcount;
    bit        present_cfg;
    bit        protect_cfg;

    t_out pending_out [$];
    int   error_count;
    int   result_count;
    int   item_count;
    int   format_count;
    bit   quiet;

    function void model_reset();
        foreach (disk_image[i]) disk_image[i] = BLANK_BYTE;
        foreach (main_buf[i]) main_buf[i] = 8'd0;
        foreach (aux_buf[i]) aux_buf[i] = 8'd0;
        status_byte = 0; lmode = 0; tmode = 0; bptr = 0; sptr = 0;
        seek_acc = 0; seek_hi_done = 0; partial_on = 0; tcount = 0;
        present_cfg = 1; protect_cfg = 0;
    endfunction

    function void bump_sector();
        if (sptr != 16'hFFFF) sptr = sptr + 16'd1;
    endfunction

    function void load_sector();
        if (!present_cfg) return;
        for (int i = 0; i < 256; i++)
            main_buf[i] = (sptr < NUM_SECTORS) ? disk_image[int'(sptr) * 256 + i] : BLANK_BYTE;
    endfunction

    function void store_sector();
        if (!present_cfg || protect_cfg || sptr >= NUM_SECTORS) return;
        for (int i = 0; i < 256; i++) disk_image[int'(sptr) * 256 + i] = main_buf[i];
    endfunction

    function void exchange_buffers();
        bit [7:0] tmp [256];
        bptr = 0;
        tmp = aux_buf;
        aux_buf = main_buf;
        main_buf = tmp;
    endfunction

    function void take_byte(bit [7:0] b, bit last);
        case (lmode)
            L_DATA, L_DATA_BP0, L_PARTIAL: begin
                main_buf[bptr] = b;
                bptr = bptr + 8'd1;
                if (bptr == 0) begin
                    store_sector();
                    bump_sector();
                    if (partial_on) load_sector();
                end else if (last) begin
                    store_sector();
                    if (!partial_on) bump_sector();
                end
            end
            L_AUX: begin
                aux_buf[bptr] = b;
                bptr = bptr + 8'd1;
            end
            L_SET_BP: bptr = b;
            L_SEEK: begin
                if (seek_hi_done) begin
                    seek_acc[7:0] = b;
                    if (seek_acc < NUM_SECTORS) begin
                        sptr = seek_acc;
                        status_byte = 0;
                    end else begin
                        status_byte = STATUS_SEEK_ERR;
                    end
                    seek_hi_done = 0;
                end else begin
                    seek_acc[15:8] = b;
                    seek_hi_done = 1;
                end
            end
            default: ;
        endcase
    endfunction

    // Returns the next talker byte; have is cleared when there is nothing to send.
    function bit [7:0] give_byte(output bit have);
        bit [7:0] v;
        v = 0;
        have = 0;
        case (tmode)
            T_DATA, T_READ: begin
                v = main_buf[bptr]; have = 1;
                bptr = bptr + 8'd1;
                if (bptr == 0) begin
                    load_sector();
                    bump_sector();
                end
            end
            T_AUX: begin
                v = aux_buf[bptr]; have = 1;
                bptr = bptr + 8'd1;
                if (bptr == 0) tmode = T_DONE;
            end
            T_POS: begin
                if (tcount == 0) begin v = sptr[15:8]; have = 1; end
                else if (tcount == 1) begin v = sptr[7:0]; have = 1; end
                else if (tcount == 2) begin v = bptr; have = 1; end
                if (tcount != 4'd15) tcount++;
            end
            T_GEOM: begin
                if (tcount < GEOM_LEN) begin
                    case (tcount)
                        4'd3: v = 8'd80;
                        4'd7: v = 8'd2;
                        4'd11: v = 8'd16;
                        default: v = 8'd0;
                    endcase
                    have = 1;
                    tcount++;
                end
            end
            T_SIZE: begin
                if (tcount == 0) begin v = 8'((NUM_SECTORS >> 8) & 255); have = 1; end
                else if (tcount == 1) begin v = 8'(NUM_SECTORS & 255); have = 1; end
                if (tcount != 4'd15) tcount++;
            end
            default: ;
        endcase
        return v;
    endfunction

    function void run_command(bit [7:0] f, bit la, bit ta);
        bit [4:0] n;
        n = f[4:0];
        if (f[7:5] == GRP_LISTEN) begin
            if (!(la && !ta)) return;
            lmode = n;
            case (n)
                L_AUX: partial_on = 0;
                L_DATA_BP0: begin bptr = 0; partial_on = 0; end
                L_SEEK: begin partial_on = 0; seek_hi_done = 0; end
                L_FORMAT: begin
                    status_byte = 0;
                    if (present_cfg && !protect_cfg)
                        foreach (disk_image[i]) disk_image[i] = BLANK_BYTE;
                end
                L_PARTIAL: begin partial_on = 1; load_sector(); end
                L_RESET_PTR: begin seek_hi_done = 0; sptr = 0; bptr = 0; end
                L_FLUSH: begin
                    store_sector();
                    if (!partial_on) bump_sector();
                end
                L_COPY: begin bptr = 0; aux_buf = main_buf; end
                L_SWAP: exchange_buffers();
                default: ;
            endcase
        end else if (f[7:5] == GRP_TALK) begin
            if (!ta) return;
            tmode = n;
            tcount = 0;
            case (n)
                T_DATA: partial_on = 0;
                T_READ: begin
                    load_sector();
                    bptr = 0;
                    partial_on = 0;
                    bump_sector();
                end
                T_SWAP: exchange_buffers();
                default: ;
            endcase
        end
    endfunction

    function t_out drive_model_step(t_in x);
        t_out r;
        bit   have;
        bit [7:0] v;
        r = '0;
        case (x.action)
            ACT_DATA_IN: take_byte(x.frame_byte, x.end_mark);
            ACT_REQ_OUT: begin
                v = give_byte(have);
                if (have) r.out_value = v;
                else r.no_data = 1'b1;
            end
            ACT_STATUS: begin
                r.out_value = status_byte;
                status_byte = status_byte & STATUS_KEEP;
            end
            ACT_CLEAR: begin seek_hi_done = 0; sptr = 0; bptr = 0; end
            ACT_COMMAND: begin
                run_command(x.frame_byte, x.listen_addressed, x.talk_addressed);
                r.out_value = x.frame_byte;
            end
            default: ;
        endcase
        return r;
    endfunction

    // Sends one transaction after a random gap; valid stays high across
    // back-to-back transactions. The prediction is taken at the accepting edge.
    task send_item(t_in x, bit use_typed, t_out typed);
        int   gap;
        t_out pred;
        if (!quiet && $urandom_range(0, 29) == 0) quiet = 1;
        else if (quiet && $urandom_range(0, 39) == 0) quiet = 0;
        gap = quiet ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= x;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (x.action == ACT_COMMAND && x.frame_byte == {GRP_LISTEN, L_FORMAT}
                && x.listen_addressed && !x.talk_addressed)
            format_count++;
        pred = drive_model_step(x);
        pending_out.push_back(use_typed ? typed : pred);
        item_count++;
    endtask

    function t_in mk(bit [2:0] a, bit [7:0] fb, bit e, bit la, bit ta);
        t_in x;
        x.action = a; x.frame_byte = fb; x.end_mark = e;
        x.listen_addressed = la; x.talk_addressed = ta;
        return x;
    endfunction

    function t_out res(bit [7:0] v, bit nd);
        t_out r;
        r.out_value = v; r.no_data = nd;
        return r;
    endfunction

    // Directed table: stimulus, whether the expected result is typed in, and that result.
    t_in  dir_item [$];
    bit   dir_typed [$];
    t_out dir_want [$];

    task add_row(t_in x, bit typed, t_out w);
        dir_item.push_back(x);
        dir_typed.push_back(typed);
        dir_want.push_back(w);
    endtask

    task wait_idle();
        int guard;
        guard = 0;
        while (pending_out.size() != 0 && guard < 400000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task write_cfg(bit present, bit protect);
        wait_idle();
        i_cfg_we <= 1'b1; i_cfg_idx <= 1'b0; i_cfg_data <= present;
        @(posedge i_clk);
        i_cfg_idx <= 1'b1; i_cfg_data <= protect;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        present_cfg = present;
        protect_cfg = protect;
        @(posedge i_clk);
    endtask

    // One random sequence: mostly a command followed by its data or requests.
    task random_sequence();
        int kind;
        int len;
        bit [4:0] n;
        bit [7:0] b;
        t_out none;
        none = '0;
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
            n = 5'($urandom_range(0, 11));
            if (n == L_FORMAT && $urandom_range(0, 14) != 0) n = L_DATA;
            if (n == 11) n = 5'($urandom_range(0, 31));
            send_item(mk(ACT_COMMAND, {GRP_LISTEN, n}, 1'($urandom_range(0, 1)), 1'b1,
                         ($urandom_range(0, 9) == 0)), 0, none);
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(250, 270)
                                               : $urandom_range(1, 12);
            if (n == L_SEEK) len = 2;
            for (int i = 0; i < len; i++) begin
                b = 8'($urandom_range(0, 255));
                if (n == L_SEEK && i == 0 && $urandom_range(0, 4) != 0)
                    b = 8'($urandom_range(0, 10));
                send_item(mk(ACT_DATA_IN, b, ($urandom_range(0, 9) == 0),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))), 0, none);
            end
        end else if (kind < 85) begin
            case ($urandom_range(0, 8))
                0: n = T_DATA;
                1: n = T_AUX;
                2: n = T_READ;
                3: n = T_POS;
                4: n = T_SWAP;
                5: n = T_GEOM;
                6: n = T_SIZE;
                default: n = 5'($urandom_range(0, 31));
            endcase
            send_item(mk(ACT_COMMAND, {GRP_TALK, n}, 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), ($urandom_range(0, 9) != 0)), 0, none);
            len = ($urandom_range(0, 24) == 0) ? $urandom_range(250, 270)
                                               : $urandom_range(1, 18);
            for (int i = 0; i < len; i++)
                send_item(mk(ACT_REQ_OUT, 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1))), 0, none);
        end else begin
            // Noise: any action with any fields, formats filtered to keep the run short.
            b = 8'($urandom_range(0, 255));
            if (b == {GRP_LISTEN, L_FORMAT}) b = 8'h00;
            send_item(mk(3'($urandom_range(0, 7)), b, 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))), 0, none);
        end
    endtask

    // Result side: random stall per transaction, compared with the oldest expectation.
    int hold = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            result_count++;
            if (pending_out.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result value=%0d no_data=%0d",
                             o_out.out_value, o_out.no_data);
            end else begin
                if (o_out !== pending_out[0]) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("mismatch #%0d: expected %0d/%0d, got %0d/%0d",
                                 result_count, pending_out[0].out_value,
                                 pending_out[0].no_data, o_out.out_value, o_out.no_data);
                end
                void'(pending_out.pop_front());
            end
            hold = quiet ? 0 : $urandom_range(0, 17);
        end else if (hold > 0) begin
            hold--;
        end
        i_out_stall <= (hold != 0);
    end

    initial begin
        #20000000;
        $display("[loop_mass_storage_drive] ERROR");
        $finish;
    end

    initial begin
        t_out none;
        none = '0;
        error_count = 0; result_count = 0; item_count = 0; format_count = 0;
        quiet = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = 1'b0;
        i_cfg_data = 1'b0;
        model_reset();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Status after reset, a request from the zeroed buffer, a seek past the
        // end with its error and the sticky-bit clear, size readback,
        // geometry, pointer readback, reads beyond the store, ignored frames.
        add_row(mk(ACT_STATUS, 8'h00, 0, 0, 0), 1, res(8'd0, 0));
        add_row(mk(ACT_REQ_OUT, 8'h00, 0, 0, 1), 1, res(8'd0, 0));
        add_row(mk(ACT_COMMAND, {GRP_LISTEN, L_SEEK}, 0, 1, 0), 1, res({GRP_LISTEN, L_SEEK}, 0));
        add_row(mk(ACT_DATA_IN, 8'hFF, 0, 1, 0), 1, res(8'd0, 0));
        add_row(mk(ACT_DATA_IN, 8'hFF, 1, 1, 0), 1, res(8'd0, 0));
        add_row(mk(ACT_STATUS, 8'hFF, 1, 1, 1), 1, res(STATUS_SEEK_ERR, 0));
        add_row(mk(ACT_STATUS, 8'h00, 0, 0, 0), 1, res(8'd0, 0));
        add_row(mk(ACT_COMMAND, {GRP_TALK, T_SIZE}, 0, 0, 1), 1, res({GRP_TALK, T_SIZE}, 0));
        add_row(mk(ACT_REQ_OUT, 8'h00, 0, 0, 1), 1, res(8'h0A, 0));
        add_row(mk(ACT_REQ_OUT, 8'h00, 0, 0, 1), 1, res(8'h00, 0));
        add_row(mk(ACT_REQ_OUT, 8'h00, 0, 0, 1), 1, res(8'h00, 1));
        add_row(mk(ACT_COMMAND, {GRP_TALK, T_GEOM}, 0, 0, 1), 1, res({GRP_TALK, T_GEOM}, 0));
        for (int i = 0; i < 4; i++) add_row(mk(ACT_REQ_OUT, 8'h00, 0, 0, 1), 0, none);
        add_row(mk(ACT_COMMAND, {GRP_LISTEN, L_SEEK}, 0, 1, 0), 0, none);
        add_row(mk(ACT_DATA_IN, 8'h09, 0, 1, 0), 0, none);
        add_row(mk(ACT_DATA_IN, 8'hFF, 0, 1, 0), 0, none);
        add_row(mk(ACT_COMMAND, {GRP_LISTEN, L_FLUSH}, 0, 1, 0), 0, none);
        add_row(mk(ACT_COMMAND, {GRP_TALK, T_READ}, 0, 1, 1), 0, none);
        add_row(mk(ACT_REQ_OUT, 8'h00, 0, 0, 1), 1, res(BLANK_BYTE, 0));
        add_row(mk(ACT_COMMAND, {GRP_LISTEN, L_RESET_PTR}, 0, 1, 1), 1,
                res({GRP_LISTEN, L_RESET_PTR}, 0));
        add_row(mk(3'd7, 8'hFF, 1, 1, 1), 1, res(8'd0, 0));
        add_row(mk(ACT_COMMAND, 8'h1F, 1, 1, 1), 1, res(8'h1F, 0));
        add_row(mk(ACT_COMMAND, {GRP_TALK, T_POS}, 0, 0, 1), 0, none);
        add_row(mk(ACT_REQ_OUT, 8'h00, 0, 0, 1), 0, none);
        add_row(mk(ACT_COMMAND, {GRP_LISTEN, L_FORMAT}, 0, 1, 0), 0, none);

        for (int i = 0; i < dir_item.size(); i++)
            send_item(dir_item[i], dir_typed[i], dir_want[i]);
        i_in_valid <= 1'b0;

        // Phases over the drive settings, both registers written every time.
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: write_cfg(1'b1, 1'b0);
                1: write_cfg(1'b0, 1'b0);
                2: write_cfg(1'b1, 1'b1);
                3: write_cfg(1'b0, 1'b1);
                default: write_cfg(1'b1, 1'b0);
            endcase
            while (item_count < dir_item.size() + (ph + 1) * 255) random_sequence();
            i_in_valid <= 1'b0;
        end

        wait_idle();
        $display("Covered %0d input transactions and %0d results over five drive settings,",
                 item_count, result_count);
        $display("including %0d format commands and %0d directed rows.",
                 format_count, dir_item.size());
        if (error_count == 0 && pending_out.size() == 0) begin
            $display("[loop_mass_storage_drive] OK");
        end else begin
            $display("[loop_mass_storage_drive] ERROR");
        end
        $finish;
    end

endmodule

// ----- loop_mass_storage_drive.f -----
sv/lmsd_pkg.sv
sv/lmsd_ram.sv
sv/loop_mass_storage_drive.sv
dv/testbench.sv
